FILE: src/tdfe_pkg.sv
// Package for the table-driven multi-diagram state machine engine.
// Holds sizing constants, command codes, the line and setup record types
// and the sequencer state type. No dependencies.
package tdfe_pkg;

  localparam int DIAGRAM_COUNT = 4;
  localparam int MAX_LINES     = 16;
  localparam int STATE_WIDTH   = 8;
  localparam int EVENT_WIDTH   = 8;

  localparam int DG_W   = (DIAGRAM_COUNT > 1) ? $clog2(DIAGRAM_COUNT) : 1;
  localparam int LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CNT_W  = $clog2(MAX_LINES + 1);
  localparam int ADDR_W = DG_W + LINE_W;
  localparam int DEPTH  = DIAGRAM_COUNT * (1 << LINE_W);

  localparam logic [1:0] CMD_WRITE_LINE  = 2'd0;
  localparam logic [1:0] CMD_WRITE_SETUP = 2'd1;
  localparam logic [1:0] CMD_EVENT       = 2'd2;

  // One transition line as held in the line memory.
  typedef struct packed {
    logic [STATE_WIDTH-1:0] src;
    logic [EVENT_WIDTH-1:0] ev;
    logic [3:0]             cond;
    logic [STATE_WIDTH-1:0] dst;
    logic [7:0]             act;
    logic [15:0]            time_val;
  } line_t;

  typedef struct packed {
    logic [CNT_W-1:0]       count;
    logic [EVENT_WIDTH-1:0] timer_ev;
  } setup_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRE,
    S_TIMER,
    S_OUT
  } seq_state_t;

endpackage

FILE: src/tdfe_req_if.sv
// Request channel of the engine: valid/ready handshake plus command fields.
// No dependencies.
interface tdfe_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  diagram;
  logic [3:0]  line;
  logic [7:0]  from_state;
  logic [7:0]  event_id;
  logic [3:0]  cond_index;
  logic [7:0]  to_state;
  logic [7:0]  action_id;
  logic [15:0] timer_time;
  logic [4:0]  line_count;
  logic [15:0] cond_flags;

  modport source (
    output valid, cmd, diagram, line, from_state, event_id, cond_index,
           to_state, action_id, timer_time, line_count, cond_flags,
    input  ready
  );
  modport sink (
    input  valid, cmd, diagram, line, from_state, event_id, cond_index,
           to_state, action_id, timer_time, line_count, cond_flags,
    output ready
  );
endinterface

FILE: src/tdfe_rsp_if.sv
// Result channel of the engine: valid/ready handshake plus per-diagram report.
// No dependencies.
interface tdfe_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  diagram_out;
  logic        fired;
  logic [7:0]  new_state;
  logic [7:0]  action_out;
  logic        timer_start;
  logic [15:0] timer_start_time;
  logic        last;

  modport source (
    output valid, diagram_out, fired, new_state, action_out, timer_start,
           timer_start_time, last,
    input  ready
  );
  modport sink (
    input  valid, diagram_out, fired, new_state, action_out, timer_start,
           timer_start_time, last,
    output ready
  );
endinterface

FILE: src/tdfe_line_mem.sv
// Transition line memory: one write port, one read port, registered read data.
// Depends on tdfe_pkg for the line record and address width.
module tdfe_line_mem
  import tdfe_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  line_t             wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output line_t             rd_data
);

  line_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/table_driven_multi_fsm_engine_unit.sv
// Table-driven multi-diagram state machine engine, top level.
// Line and setup writes are accepted while the sequencer is idle, give no result and may follow back to back.
// An event item is worked one diagram at a time; for each diagram a fire scan reads one line
// per cycle, a timer scan follows only when a line fired, and the result is then offered on
// the result channel, which can stall; no new request is taken until the last result is taken.
// Synchronous active-high reset clears setups, current states and the sequencer.
module table_driven_multi_fsm_engine_unit
  import tdfe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tdfe_req_if.sink   req,
  tdfe_rsp_if.source rsp
);

  // Sequencer state and per-event working registers.
  seq_state_t             state, state_next;
  logic [DG_W-1:0]        d;
  logic [CNT_W-1:0]       idx;
  logic                   pend;
  logic [EVENT_WIDTH-1:0] ev;
  logic [15:0]            flags;
  logic                   fired;
  logic [7:0]             action;
  logic                   tstart;
  logic [15:0]            ttime;
  logic [STATE_WIDTH-1:0] cur;

  // Small per-diagram stores kept in flip-flops so reset clears them at once.
  setup_t                 setup     [DIAGRAM_COUNT];
  logic [STATE_WIDTH-1:0] cur_state [DIAGRAM_COUNT];

  // Line memory ports.
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  line_t             mem_wr_data;
  logic [ADDR_W-1:0] mem_rd_addr;
  line_t             mem_rd_data;

  logic accept;
  logic dg_ok;
  logic ln_ok;
  logic fire_hit;
  logic timer_hit;
  logic issue;
  logic start_diag;
  logic last_diag;
  setup_t cur_setup;

  assign accept    = req.valid && req.ready;
  assign dg_ok     = int'(req.diagram) < DIAGRAM_COUNT;
  assign ln_ok     = int'(req.line) < MAX_LINES;
  assign cur_setup = setup[d];
  assign last_diag = int'(d) == DIAGRAM_COUNT - 1;

  // A line fires when it leaves the current state on the delivered event and
  // its guarding condition flag is set. The timer search looks for the first
  // line out of the new state on the diagram's timer event.
  assign fire_hit  = pend && (mem_rd_data.src == cur_state[d]) &&
                     (mem_rd_data.ev == ev) && flags[mem_rd_data.cond];
  assign timer_hit = pend && (mem_rd_data.src == cur) &&
                     (mem_rd_data.ev == cur_setup.timer_ev);

  assign mem_wr_en   = accept && (req.cmd == CMD_WRITE_LINE) && dg_ok && ln_ok;
  assign mem_wr_addr = {DG_W'(req.diagram), LINE_W'(req.line)};
  assign mem_wr_data = '{
    src:      STATE_WIDTH'(req.from_state),
    ev:       EVENT_WIDTH'(req.event_id),
    cond:     req.cond_index,
    dst:      STATE_WIDTH'(req.to_state),
    act:      req.action_id,
    time_val: req.timer_time
  };
  assign mem_rd_addr = {d, idx[LINE_W-1:0]};

  tdfe_line_mem u_line_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes. Both scans issue one memory read per cycle and
  // check the line read in the previous cycle; a hit ends the scan and no
  // further read is issued.
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    start_diag = 1'b0;
    req.ready  = 1'b0;
    rsp.valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        // Ready is always high here, so a valid event item is accepted.
        req.ready = 1'b1;
        if (req.valid && (req.cmd == CMD_EVENT)) begin
          start_diag = 1'b1;
          state_next = S_FIRE;
        end
      end
      S_FIRE: begin
        if (fire_hit) begin
          state_next = S_TIMER;
        end else if (idx < cur_setup.count) begin
          issue = 1'b1;
        end else begin
          state_next = S_OUT;
        end
      end
      S_TIMER: begin
        if (timer_hit) begin
          state_next = S_OUT;
        end else if (idx < cur_setup.count) begin
          issue = 1'b1;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        rsp.valid = 1'b1;
        if (rsp.ready) begin
          if (last_diag) begin
            state_next = S_IDLE;
          end else begin
            start_diag = 1'b1;
            state_next = S_FIRE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Scan pointer, diagram counter and pending-read flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      d    <= '0;
      idx  <= '0;
      pend <= 1'b0;
    end else begin
      if (state == S_IDLE && start_diag) begin
        d <= '0;
      end else if (state == S_OUT && start_diag) begin
        d <= d + 1'b1;
      end
      if (start_diag || (state == S_FIRE && fire_hit)) begin
        idx  <= '0;
        pend <= 1'b0;
      end else begin
        if (issue) begin
          idx <= idx + 1'b1;
        end
        pend <= issue;
      end
    end
  end

  // Per-event payload and per-diagram outcome.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      ev    <= EVENT_WIDTH'(req.event_id);
      flags <= req.cond_flags;
    end
    if (start_diag) begin
      fired  <= 1'b0;
      action <= '0;
      tstart <= 1'b0;
      ttime  <= '0;
    end else if (state == S_FIRE && fire_hit) begin
      fired  <= 1'b1;
      action <= mem_rd_data.act;
      cur    <= mem_rd_data.dst;
    end else if (state == S_TIMER && timer_hit) begin
      tstart <= 1'b1;
      ttime  <= mem_rd_data.time_val;
    end
  end

  // Setup writes and the state update of a fired diagram.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIAGRAM_COUNT; k++) begin
        setup[k]     <= '0;
        cur_state[k] <= '0;
      end
    end else begin
      if (accept && (req.cmd == CMD_WRITE_SETUP) && dg_ok) begin
        setup[DG_W'(req.diagram)].count    <= (int'(req.line_count) > MAX_LINES) ?
                                              CNT_W'(MAX_LINES) : CNT_W'(req.line_count);
        setup[DG_W'(req.diagram)].timer_ev <= EVENT_WIDTH'(req.event_id);
        cur_state[DG_W'(req.diagram)]      <= STATE_WIDTH'(req.from_state);
      end else if (state == S_FIRE && fire_hit) begin
        cur_state[d] <= mem_rd_data.dst;
      end
    end
  end

  assign rsp.diagram_out      = 2'(d);
  assign rsp.fired            = fired;
  assign rsp.new_state        = 8'(cur_state[d]);
  assign rsp.action_out       = action;
  assign rsp.timer_start      = tstart;
  assign rsp.timer_start_time = ttime;
  assign rsp.last             = last_diag;

endmodule

FILE: test/tb_table_driven_multi_fsm_engine_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the table-driven multi-diagram state machine engine.
// It needs tdfe_pkg and the request and result interfaces. A directed table is
// followed by random diagram programs and events, scored against a local predictor and typed reports.
module tb_table_driven_multi_fsm_engine_unit;
  import tdfe_pkg::*;

  // Command code that the engine must ignore.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int N_DIR        = 19;
  localparam int RANDOM_ITEMS = 80;
  // The drain wait is sized to cover an event over four full diagrams. The cycle
  // limit covers every item at its slowest, with stalls on both sides, many times
  // over.
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 500000;

  // One request item as it appears on the request channel.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  diagram;
    logic [3:0]  line;
    logic [7:0]  from_state;
    logic [7:0]  event_id;
    logic [3:0]  cond_index;
    logic [7:0]  to_state;
    logic [7:0]  action_id;
    logic [15:0] timer_time;
    logic [4:0]  line_count;
    logic [15:0] cond_flags;
  } engine_req_t;

  // One per-diagram report as it appears on the result channel.
  typedef struct packed {
    logic [1:0]  diagram;
    logic        fired;
    logic [7:0]  new_state;
    logic [7:0]  action;
    logic        timer_start;
    logic [15:0] timer_time;
    logic        last;
  } diag_report_t;

  // A directed row. Where has_typed is set, the typed report replaces the
  // predicted one for the diagram that it names.
  typedef struct {
    engine_req_t  req;
    bit           has_typed;
    diag_report_t typed;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tdfe_req_if req_bus ();
  tdfe_rsp_if rsp_bus ();

  table_driven_multi_fsm_engine_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the engine's line memory, setups and current states,
  // plus a record of which lines have been written. Setup counts are kept
  // within the written prefix of a diagram, so that no unwritten line is
  // ever scanned.
  line_t        model_lines [DIAGRAM_COUNT][MAX_LINES];
  setup_t       model_setup [DIAGRAM_COUNT];
  logic [7:0]   model_state [DIAGRAM_COUNT];
  bit           line_written [DIAGRAM_COUNT][MAX_LINES];

  diag_report_t pending_reports [$];
  diag_report_t step_reports [$];
  dir_row_t     dir_tab [N_DIR];

  int fail_count  = 0;
  int cycle_count = 0;
  int items_sent  = 0;
  int work_items  = 0;
  int tx_idle_pct = 16;
  int rx_idle_pct = 48;

  // Predictor: applies one accepted item to the local copy of the engine.
  // For an event, it computes one report per diagram into step_reports.
  task automatic engine_model_step(input engine_req_t r);
    diag_report_t rep;
    line_t        ent;
    int           lines;
    bit           hit;
    step_reports.delete();
    case (r.cmd)
      CMD_WRITE_LINE: begin
        model_lines[r.diagram][r.line] = '{src: r.from_state, ev: r.event_id,
                                           cond: r.cond_index, dst: r.to_state,
                                           act: r.action_id, time_val: r.timer_time};
        line_written[r.diagram][r.line] = 1'b1;
      end
      CMD_WRITE_SETUP: begin
        // A count above the table size saturates to the table size.
        model_setup[r.diagram].count    = (r.line_count > MAX_LINES) ?
                                          CNT_W'(MAX_LINES) : r.line_count;
        model_setup[r.diagram].timer_ev = r.event_id;
        model_state[r.diagram]          = r.from_state;
      end
      CMD_EVENT: begin
        for (int d = 0; d < DIAGRAM_COUNT; d++) begin
          rep         = '0;
          rep.diagram = 2'(d);
          rep.last    = (d == DIAGRAM_COUNT - 1);
          lines       = model_setup[d].count;
          hit         = 1'b0;
          // The first line that matches state, event and guard fires.
          for (int i = 0; i < lines && !hit; i++) begin
            ent = model_lines[d][i];
            if (ent.src == model_state[d] && ent.ev == r.event_id &&
                r.cond_flags[ent.cond]) begin
              hit            = 1'b1;
              model_state[d] = ent.dst;
              rep.fired      = 1'b1;
              rep.action     = ent.act;
              // Then the first timer line of the new state starts a timer.
              for (int j = 0; j < lines && !rep.timer_start; j++) begin
                if (model_lines[d][j].src == model_state[d] &&
                    model_lines[d][j].ev == model_setup[d].timer_ev) begin
                  rep.timer_start = 1'b1;
                  rep.timer_time  = model_lines[d][j].time_val;
                end
              end
            end
          end
          rep.new_state = model_state[d];
          step_reports.push_back(rep);
        end
      end
      default: ;
    endcase
  endtask

  // Length of the run of written lines starting at line zero.
  function automatic int written_prefix(input int d);
    int n;
    n = 0;
    while (n < MAX_LINES && line_written[d][n]) n++;
    return n;
  endfunction

  // Every field but the command random; callers then shape the fields that matter.
  function automatic engine_req_t random_fields();
    engine_req_t r;
    r.cmd        = CMD_EVENT;
    r.diagram    = 2'($urandom_range(0, 3));
    r.line       = 4'($urandom_range(0, 15));
    r.from_state = 8'($urandom);
    r.event_id   = 8'($urandom);
    r.cond_index = 4'($urandom);
    r.to_state   = 8'($urandom);
    r.action_id  = 8'($urandom);
    r.timer_time = 16'($urandom);
    r.line_count = 5'($urandom);
    r.cond_flags = 16'($urandom);
    return r;
  endfunction

  // States and events are mostly drawn from a small set so that lines match
  // and diagrams move. Now and then a value from the full range comes in.
  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 3));
  endfunction

  // Drives one item. It is entered just after a falling edge and returns
  // just after the falling edge that follows acceptance, with valid still
  // high, so that back-to-back items never lower and raise valid in one step.
  task automatic send_req(input engine_req_t r, input bit has_typed,
                          input diag_report_t typed);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.cmd        <= r.cmd;
    req_bus.diagram    <= r.diagram;
    req_bus.line       <= r.line;
    req_bus.from_state <= r.from_state;
    req_bus.event_id   <= r.event_id;
    req_bus.cond_index <= r.cond_index;
    req_bus.to_state   <= r.to_state;
    req_bus.action_id  <= r.action_id;
    req_bus.timer_time <= r.timer_time;
    req_bus.line_count <= r.line_count;
    req_bus.cond_flags <= r.cond_flags;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    engine_model_step(r);
    if (has_typed && step_reports.size() > typed.diagram)
      step_reports[typed.diagram] = typed;
    foreach (step_reports[k]) pending_reports.push_back(step_reports[k]);
    items_sent++;
    if (r.cmd != CMD_UNUSED) work_items++;
    // Idle profile: sender light and receiver heavy, then swapped, then none.
    if (items_sent < 40) begin
      tx_idle_pct = 16;
      rx_idle_pct = 48;
    end else if (items_sent < 80) begin
      tx_idle_pct = 48;
      rx_idle_pct = 16;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    @(negedge clk);
  endtask

  // Holds the sender off until every report in flight has come back.
  task automatic hold_until_drained();
    req_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Receiver: ready changes at the falling edge at the idle rate of the phase.
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Scoreboard: each accepted report is compared with the oldest one expected.
  diag_report_t want_rep;
  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_reports.size() == 0) begin
        $error("report for diagram %0d arrived with none expected",
               rsp_bus.diagram_out);
        fail_count++;
      end else begin
        want_rep = pending_reports.pop_front();
        check_field("diagram_out", want_rep.diagram, rsp_bus.diagram_out);
        check_field("fired", want_rep.fired, rsp_bus.fired);
        check_field("new_state", want_rep.new_state, rsp_bus.new_state);
        check_field("action_out", want_rep.action, rsp_bus.action_out);
        check_field("timer_start", want_rep.timer_start, rsp_bus.timer_start);
        check_field("timer_start_time", want_rep.timer_time,
                    rsp_bus.timer_start_time);
        check_field("last", want_rep.last, rsp_bus.last);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("table_driven_multi_fsm_engine_unit: mismatch");
      $finish;
    end
  end

  initial begin
    engine_req_t r;
    int          d;
    int          n;
    int          pre;
    int          sel;
    int          target;
    bit          first_program;

    // Directed table. Reports typed in here follow directly from the rows
    // before them; the rest are left to the predictor.
    // Event right after reset: no lines anywhere, every diagram stays at zero.
    dir_tab[0]  = '{'{CMD_EVENT, 2'd0, 4'd0, 8'h00, 8'hFF, 4'd0, 8'h00, 8'h00,
                      16'h0000, 5'd0, 16'hFFFF},
                    1'b1, '{2'd0, 1'b0, 8'h00, 8'h00, 1'b0, 16'h0000, 1'b0}};
    // The unused command with every field at its top value is ignored.
    dir_tab[1]  = '{'{CMD_UNUSED, 2'd3, 4'hF, 8'hFF, 8'hFF, 4'hF, 8'hFF, 8'hFF,
                      16'hFFFF, 5'h1F, 16'hFFFF}, 1'b0, '0};
    // Diagram 0: state 00 goes to FF on event FF under guard 15, and state FF
    // returns to 00 on event 00 under guard 0. Event 00 is also the timer event.
    dir_tab[2]  = '{'{CMD_WRITE_LINE, 2'd0, 4'd0, 8'h00, 8'hFF, 4'hF, 8'hFF, 8'hFF,
                      16'hFFFF, 5'd0, 16'h0000}, 1'b0, '0};
    dir_tab[3]  = '{'{CMD_WRITE_LINE, 2'd0, 4'd1, 8'hFF, 8'h00, 4'h0, 8'h00, 8'h00,
                      16'hABCD, 5'd0, 16'h0000}, 1'b0, '0};
    dir_tab[4]  = '{'{CMD_WRITE_SETUP, 2'd0, 4'd0, 8'h00, 8'h00, 4'd0, 8'h00, 8'h00,
                      16'h0000, 5'd2, 16'h0000}, 1'b0, '0};
    // Top guard bit alone fires line 0; state FF has a timer line.
    dir_tab[5]  = '{'{CMD_EVENT, 2'd0, 4'd0, 8'h00, 8'hFF, 4'd0, 8'h00, 8'h00,
                      16'h0000, 5'd0, 16'h8000},
                    1'b1, '{2'd0, 1'b1, 8'hFF, 8'hFF, 1'b1, 16'hABCD, 1'b0}};
    // Nothing fires, so no timer start even though the state has a timer line.
    dir_tab[6]  = '{'{CMD_EVENT, 2'd0, 4'd0, 8'h00, 8'hFF, 4'd0, 8'h00, 8'h00,
                      16'h0000, 5'd0, 16'h7FFF},
                    1'b1, '{2'd0, 1'b0, 8'hFF, 8'h00, 1'b0, 16'h0000, 1'b0}};
    // Bottom guard bit fires line 1 back to state 00, which has no timer line.
    dir_tab[7]  = '{'{CMD_EVENT, 2'd0, 4'd0, 8'h00, 8'h00, 4'd0, 8'h00, 8'h00,
                      16'h0000, 5'd0, 16'h0001},
                    1'b1, '{2'd0, 1'b1, 8'h00, 8'h00, 1'b0, 16'h0000, 1'b0}};
    // Diagram 1 with no lines reports only its initial state.
    dir_tab[8]  = '{'{CMD_WRITE_SETUP, 2'd1, 4'd0, 8'hAA, 8'h55, 4'd0, 8'h00, 8'h00,
                      16'h0000, 5'd0, 16'h0000}, 1'b0, '0};
    dir_tab[9]  = '{'{CMD_EVENT, 2'd0, 4'd0, 8'h00, 8'h55, 4'd0, 8'h00, 8'h00,
                      16'h0000, 5'd0, 16'hFFFF},
                    1'b1, '{2'd1, 1'b0, 8'hAA, 8'h00, 1'b0, 16'h0000, 1'b0}};
    // Diagram 2: two lines compete on one state and event under different
    // guards, and the target state has two timer lines of which the first wins.
    dir_tab[10] = '{'{CMD_WRITE_LINE, 2'd2, 4'd0, 8'h01, 8'h07, 4'd3, 8'h02, 8'h11,
                      16'h0000, 5'd0, 16'h0000}, 1'b0, '0};
    dir_tab[11] = '{'{CMD_WRITE_LINE, 2'd2, 4'd1, 8'h01, 8'h07, 4'd4, 8'h03, 8'h22,
                      16'h0000, 5'd0, 16'h0000}, 1'b0, '0};
    dir_tab[12] = '{'{CMD_WRITE_LINE, 2'd2, 4'd2, 8'h02, 8'h09, 4'd0, 8'h00, 8'h00,
                      16'h1234, 5'd0, 16'h0000}, 1'b0, '0};
    dir_tab[13] = '{'{CMD_WRITE_LINE, 2'd2, 4'd3, 8'h02, 8'h09, 4'd0, 8'h01, 8'h00,
                      16'h5678, 5'd0, 16'h0000}, 1'b0, '0};
    dir_tab[14] = '{'{CMD_WRITE_SETUP, 2'd2, 4'd0, 8'h01, 8'h09, 4'd0, 8'h00, 8'h00,
                      16'h0000, 5'd4, 16'h0000}, 1'b0, '0};
    dir_tab[15] = '{'{CMD_EVENT, 2'd0, 4'd0, 8'h00, 8'h07, 4'd0, 8'h00, 8'h00,
                      16'h0000, 5'd0, 16'h0018}, 1'b0, '0};
    dir_tab[16] = '{'{CMD_WRITE_SETUP, 2'd2, 4'd0, 8'h01, 8'h09, 4'd0, 8'h00, 8'h00,
                      16'h0000, 5'd4, 16'h0000}, 1'b0, '0};
    dir_tab[17] = '{'{CMD_EVENT, 2'd0, 4'd0, 8'h00, 8'h07, 4'd0, 8'h00, 8'h00,
                      16'h0000, 5'd0, 16'h0010}, 1'b0, '0};
    // No guard bit set: nothing fires, and diagram 3 still sits at reset.
    dir_tab[18] = '{'{CMD_EVENT, 2'd0, 4'd0, 8'h00, 8'h00, 4'd0, 8'h00, 8'h00,
                      16'h0000, 5'd0, 16'h0000},
                    1'b1, '{2'd3, 1'b0, 8'h00, 8'h00, 1'b0, 16'h0000, 1'b1}};

    for (int i = 0; i < DIAGRAM_COUNT; i++) begin
      model_setup[i] = '0;
      model_state[i] = '0;
      for (int j = 0; j < MAX_LINES; j++) begin
        model_lines[i][j]  = '0;
        line_written[i][j] = 1'b0;
      end
    end

    req_bus.valid      = 1'b0;
    req_bus.cmd        = CMD_EVENT;
    req_bus.diagram    = '0;
    req_bus.line       = '0;
    req_bus.from_state = '0;
    req_bus.event_id   = '0;
    req_bus.cond_index = '0;
    req_bus.to_state   = '0;
    req_bus.action_id  = '0;
    req_bus.timer_time = '0;
    req_bus.line_count = '0;
    req_bus.cond_flags = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int k = 0; k < N_DIR; k++)
      send_req(dir_tab[k].req, dir_tab[k].has_typed, dir_tab[k].typed);

    // Random part. Most of it programs a diagram with a few lines, sets it up
    // and delivers events to it; the first program fills a whole diagram and
    // sets a count at or above the table size. The rest is bare events,
    // ignored commands, stray line writes and re-setups of written prefixes.
    target        = work_items + RANDOM_ITEMS;
    first_program = 1'b1;
    while (work_items < target) begin
      sel = first_program ? 0 : $urandom_range(0, 99);
      if (sel < 55) begin
        d = first_program ? DIAGRAM_COUNT - 1 : $urandom_range(0, DIAGRAM_COUNT - 1);
        n = (first_program || $urandom_range(0, 7) == 0) ? MAX_LINES
                                                         : $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          r            = random_fields();
          r.cmd        = CMD_WRITE_LINE;
          r.diagram    = 2'(d);
          r.line       = 4'(i);
          r.from_state = pick_code();
          r.event_id   = pick_code();
          r.to_state   = pick_code();
          send_req(r, 1'b0, '0);
        end
        r            = random_fields();
        r.cmd        = CMD_WRITE_SETUP;
        r.diagram    = 2'(d);
        r.line_count = (n == MAX_LINES) ? 5'($urandom_range(MAX_LINES, 31)) : 5'(n);
        r.event_id   = pick_code();
        r.from_state = pick_code();
        send_req(r, 1'b0, '0);
        // Let the engine drain completely before the events of this program.
        hold_until_drained();
        repeat ($urandom_range(2, 5)) begin
          r          = random_fields();
          r.cmd      = CMD_EVENT;
          r.event_id = pick_code();
          send_req(r, 1'b0, '0);
        end
        first_program = 1'b0;
      end else if (sel < 80) begin
        repeat ($urandom_range(1, 4)) begin
          r          = random_fields();
          r.cmd      = CMD_EVENT;
          r.event_id = pick_code();
          send_req(r, 1'b0, '0);
        end
      end else begin
        r = random_fields();
        case ($urandom_range(0, 2))
          0: r.cmd = CMD_UNUSED;
          1: r.cmd = CMD_WRITE_LINE;
          default: begin
            // The count never reaches past what has been written.
            r.cmd        = CMD_WRITE_SETUP;
            pre          = written_prefix(r.diagram);
            r.line_count = (pre == MAX_LINES && $urandom_range(0, 1)) ?
                           5'($urandom_range(MAX_LINES, 31)) : 5'($urandom_range(0, pre));
          end
        endcase
        send_req(r, 1'b0, '0);
      end
    end

    req_bus.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("table_driven_multi_fsm_engine_unit: match");
    end else begin
      $display("table_driven_multi_fsm_engine_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/tdfe_pkg.sv
src/tdfe_req_if.sv
src/tdfe_rsp_if.sv
src/tdfe_line_mem.sv
src/table_driven_multi_fsm_engine_unit.sv
test/tb_table_driven_multi_fsm_engine_unit.sv
